FILE: hw/rtl/i2c_target_message_buffer_core_macros.svh
// Assertion helpers shared by the message buffer RTL.
// All checks are clocked on aclk and are switched off while aresetn is low.
`ifndef I2C_TARGET_MESSAGE_BUFFER_CORE_MACROS_SVH
`define I2C_TARGET_MESSAGE_BUFFER_CORE_MACROS_SVH

// Condition that must hold at every clock edge.
`define IMB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define IMB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IMB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/imb_pkg.sv
package imb_pkg;

    // Bus event / host request codes
    typedef enum logic [3:0] {
        MODE_READ_ADDR  = 4'd0,
        MODE_TX_ACK     = 4'd1,
        MODE_TX_NACK    = 4'd2,
        MODE_WRITE_ADDR = 4'd3,
        MODE_RX_DATA    = 4'd4,
        MODE_STOP       = 4'd5,
        MODE_ERROR      = 4'd6,
        MODE_HOST_WR    = 4'd7,
        MODE_HOST_RD    = 4'd8,
        MODE_SET_REPLY  = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_PARTIAL = 2'd2,
        ST_ERROR   = 2'd3
    } status_t;

    localparam logic [7:0] FILLER_BYTE = 8'hFF;
    localparam int         QUEUE_DEPTH = 2;

    // Result of one transaction as decided by the front end; the buffer byte
    // (if any) is added in data.
    typedef struct packed {
        logic       tx_from_mem;
        logic       rd_from_mem;
        logic       ack_next;
        logic       busy;
        status_t    status;
        logic [7:0] error_code;
        logic       message_ready;
        logic [5:0] message_length;
        logic [7:0] data;
    } item_t;

endpackage

FILE: hw/rtl/imb_front.sv
`include "i2c_target_message_buffer_core_macros.svh"

module imb_front #(
    parameter int BUFFER_SIZE = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  imb_pkg::mode_t  mode,
    input  logic [7:0]      data_byte,
    input  logic [4:0]      host_index,
    input  logic [5:0]      reply_length,
    input  logic [7:0]      raw_code,
    output logic            out_valid,
    input  logic            out_ready,
    output imb_pkg::item_t  out_item
);
    import imb_pkg::*;

    localparam int IW = $clog2(BUFFER_SIZE + 1);
    localparam int AW = $clog2(BUFFER_SIZE);
    localparam int CW = ((IW > 6) ? IW : 6) + 1;
    localparam logic [CW-1:0] BS_C = CW'(BUFFER_SIZE);

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] reply_reg, reply_next;
    status_t       status_reg, status_next;
    logic [7:0]    error_reg, error_next;
    logic          busy_reg, busy_next;
    logic          st_valid_reg, st_valid_next;
    item_t         st_item_reg, st_item_next;
    logic [7:0]    rdata_reg;

    logic [7:0]    mem [BUFFER_SIZE];

    logic          accept;
    logic [IW-1:0] base_idx;
    logic          can_tx;
    logic [CW-1:0] hidx_c;
    logic          hidx_ok;
    logic          mem_we, mem_re;
    logic [AW-1:0] waddr, raddr;

    assign in_ready  = !st_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = st_valid_reg;

    always_comb begin
        out_item      = st_item_reg;
        out_item.data = rdata_reg;
    end

    assign base_idx = (mode == MODE_READ_ADDR) ? '0 : idx_reg;
    assign can_tx   = (CW'(base_idx) < CW'(reply_reg)) && (CW'(base_idx) < BS_C);
    assign hidx_c   = CW'(host_index);
    assign hidx_ok  = hidx_c < BS_C;

    always_comb begin
        idx_next    = idx_reg;
        reply_next  = reply_reg;
        status_next = status_reg;
        error_next  = error_reg;
        busy_next   = busy_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        waddr       = idx_reg[AW-1:0];
        raddr       = base_idx[AW-1:0];
        st_item_next                = '0;
        st_item_next.ack_next       = 1'b1;

        unique case (mode)
            MODE_READ_ADDR, MODE_TX_ACK: begin
                status_next              = ST_BUSY;
                busy_next                = 1'b1;
                st_item_next.tx_from_mem = can_tx;
                mem_re                   = can_tx;
                idx_next                 = base_idx + IW'(can_tx);
            end
            MODE_TX_NACK: begin
                status_next = (idx_reg == reply_reg) ? ST_OK : ST_PARTIAL;
                busy_next   = 1'b0;
            end
            MODE_WRITE_ADDR: begin
                idx_next    = '0;
                status_next = ST_BUSY;
                busy_next   = 1'b1;
            end
            MODE_RX_DATA: begin
                if (CW'(idx_reg) < BS_C) begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + IW'(1);
                end
                // NACK once only one free slot remains
                st_item_next.ack_next = (CW'(idx_next) + CW'(1)) < BS_C;
            end
            MODE_STOP: begin
                st_item_next.message_ready  = 1'b1;
                st_item_next.message_length = 6'(CW'(idx_reg));
                busy_next                   = 1'b0;
                if (status_reg == ST_BUSY) begin
                    status_next = ST_OK;
                end
            end
            MODE_HOST_WR: begin
                mem_we = hidx_ok;
                waddr  = hidx_c[AW-1:0];
            end
            MODE_HOST_RD: begin
                mem_re                   = hidx_ok;
                st_item_next.rd_from_mem = hidx_ok;
                raddr                    = hidx_c[AW-1:0];
            end
            MODE_SET_REPLY: begin
                reply_next = (CW'(reply_length) > BS_C) ? IW'(BUFFER_SIZE)
                                                         : IW'(reply_length);
            end
            default: begin
                // error event and undefined codes
                busy_next   = 1'b0;
                status_next = ST_ERROR;
                error_next  = raw_code;
            end
        endcase

        st_item_next.busy       = busy_next;
        st_item_next.status     = status_next;
        st_item_next.error_code = error_next;
    end

    always_comb begin
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (out_ready) begin
            st_valid_next = 1'b0;
        end else begin
            st_valid_next = st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            reply_reg    <= '0;
            status_reg   <= ST_OK;
            error_reg    <= '0;
            busy_reg     <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (accept) begin
                idx_reg    <= idx_next;
                reply_reg  <= reply_next;
                status_reg <= status_next;
                error_reg  <= error_next;
                busy_reg   <= busy_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_item_reg <= st_item_next;
        end
    end

    // Message buffer: one write and one registered read per transaction
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            mem[waddr] <= data_byte;
        end
        if (accept && mem_re) begin
            rdata_reg <= mem[raddr];
        end
    end

    `IMB_ASSERT(a_idx_range, CW'(idx_reg) <= BS_C, "buffer index beyond buffer size")
    `IMB_ASSERT(a_reply_range, CW'(reply_reg) <= BS_C, "reply size beyond buffer size")
    `IMB_ASSERT_IMP(a_busy_status, busy_reg, status_reg == ST_BUSY, "busy without busy status")
    `IMB_ASSERT_NXT(a_stage_hold, st_valid_reg && !out_ready, st_valid_reg && $stable(st_item_reg),
        "stalled front stage lost its transaction")

endmodule

FILE: hw/rtl/imb_queue.sv
`include "i2c_target_message_buffer_core_macros.svh"

module imb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    output logic            can_push,
    input  imb_pkg::item_t  push_item,
    output logic            head_valid,
    input  logic            pop,
    output imb_pkg::item_t  head_item
);
    import imb_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    item_t           slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign can_push   = count_reg != CNTW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `IMB_ASSERT(a_no_overflow, !(push && !can_push), "push into full queue")
    `IMB_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from empty queue")
    `IMB_ASSERT_NXT(a_count_hold, push && pop, $stable(count_reg), "count moved on push and pop")

endmodule

FILE: hw/rtl/imb_back.sv
module imb_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    output logic            pop,
    input  imb_pkg::item_t  head_item,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,
    output logic            m_tlast
);
    import imb_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  tx_reg, tx_next;
    logic [7:0]  rd_reg, rd_next;
    item_t       item_reg;

    assign pop = head_valid && (!out_valid_reg || m_tready);

    // Substitute the buffer byte or the idle values
    assign tx_next = head_item.tx_from_mem ? head_item.data : FILLER_BYTE;
    assign rd_next = head_item.rd_from_mem ? head_item.data : 8'h00;

    always_comb begin
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head_item;
            tx_reg   <= tx_next;
            rd_reg   <= rd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = item_reg.message_ready;
    assign m_tdata  = {6'b0, rd_reg, item_reg.message_length, item_reg.error_code,
                       item_reg.status, item_reg.busy, item_reg.ack_next, tx_reg};

endmodule

FILE: hw/rtl/i2c_target_message_buffer_core.sv
// Message layer of an I2C target: one transaction on the s_ side carries one
// classified bus event or host request (kind in s_tuser), one transaction on
// the m_ side carries its result.
//  - s_ channel: s_tuser = mode; s_tdata = data byte, host index, reply
//    length and raw bus code.
//  - m_ channel: m_tdata = tx byte, ack/NACK decision, busy, status, error
//    code, message length and host read data; m_tlast marks a stop (message
//    ready).
// Throughput: one transaction per cycle in both directions while m_ is not
// stalled. The front end updates index, status and buffer in the accepting
// cycle and reads the buffer through a registered port, so every event sees
// the state left by the one before.
// Path: the result passes the front stage, the two-entry queue and the
// output register before it is offered on m_.
// Reset: index, reply length, error code and busy clear, status goes to ok.
// Buffer contents are not cleared; unwritten entries read as undefined.
// A stalled m_ side fills the output register and queue; s_tready then
// drops and nothing is lost.
module i2c_target_message_buffer_core #(
    parameter int BUFFER_SIZE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], host_index[12:8],
                                   // reply_length[18:13], raw_code[26:19]
    input  logic [3:0]  s_tuser,   // mode[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // tx_byte[7:0], ack_next[8], busy_res[9],
                                   // status[11:10], error_code[19:12],
                                   // message_length[25:20], read_data[33:26]
    output logic        m_tlast    // message_ready
);
    import imb_pkg::*;

    logic  st_valid;
    logic  q_can_push;
    logic  q_head_valid;
    logic  q_pop;
    item_t st_item;
    item_t q_head_item;

    // Front end: classify the event, update state, access the buffer
    imb_front #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .mode         (mode_t'(s_tuser)),
        .data_byte    (s_tdata[7:0]),
        .host_index   (s_tdata[12:8]),
        .reply_length (s_tdata[18:13]),
        .raw_code     (s_tdata[26:19]),
        .out_valid    (st_valid),
        .out_ready    (q_can_push),
        .out_item     (st_item)
    );

    // Decouples the front end from a stalling receiver
    imb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (st_valid && q_can_push),
        .can_push   (q_can_push),
        .push_item  (st_item),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .head_item  (q_head_item)
    );

    // Back end: final field formatting and output register
    imb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .head_item  (q_head_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: tb/message_layer_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the message buffer, works out the result of every
// accepted event and compares it with what leaves on the m_ side.
module message_layer_checker #(
    parameter int BUFFER_SIZE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);
    import imb_pkg::*;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       ack_next;
        logic       busy;
        status_t    status;
        logic [7:0] error_code;
        logic       message_ready;
        logic [5:0] message_length;
        logic [7:0] read_data;
    } event_result_t;

    // Own copy of the message layer state
    logic [7:0]  shadow_buf [BUFFER_SIZE];
    int unsigned fill_pos;
    int unsigned reply_len;
    status_t     link_status;
    logic [7:0]  last_error;
    logic        busy_q;

    event_result_t awaited_results[$];

    function automatic logic [7:0] pull_reply_byte();
        logic [7:0] octet;
        if (fill_pos < reply_len && fill_pos < BUFFER_SIZE) begin
            octet = shadow_buf[fill_pos];
            fill_pos++;
            return octet;
        end
        return FILLER_BYTE;
    endfunction

    function automatic event_result_t resolve_event(input logic [3:0] kind,
                                                    input logic [7:0] octet,
                                                    input logic [4:0] slot,
                                                    input logic [5:0] len_req,
                                                    input logic [7:0] raw);
        event_result_t r;
        r.tx_byte        = FILLER_BYTE;
        r.ack_next       = 1'b1;
        r.message_ready  = 1'b0;
        r.message_length = '0;
        r.read_data      = '0;
        case (kind)
            MODE_READ_ADDR: begin
                fill_pos    = 0;
                link_status = ST_BUSY;
                busy_q      = 1'b1;
                r.tx_byte   = pull_reply_byte();
            end
            MODE_TX_ACK: begin
                link_status = ST_BUSY;
                busy_q      = 1'b1;
                r.tx_byte   = pull_reply_byte();
            end
            MODE_TX_NACK: begin
                link_status = (fill_pos == reply_len) ? ST_OK : ST_PARTIAL;
                busy_q      = 1'b0;
            end
            MODE_WRITE_ADDR: begin
                fill_pos    = 0;
                link_status = ST_BUSY;
                busy_q      = 1'b1;
            end
            MODE_RX_DATA: begin
                // bytes past the end are dropped
                if (fill_pos < BUFFER_SIZE) begin
                    shadow_buf[fill_pos] = octet;
                    fill_pos++;
                end
                r.ack_next = (fill_pos + 1 < BUFFER_SIZE);
            end
            MODE_STOP: begin
                r.message_ready  = 1'b1;
                r.message_length = 6'(fill_pos);
                busy_q           = 1'b0;
                if (link_status == ST_BUSY)
                    link_status = ST_OK;
            end
            MODE_HOST_WR: begin
                if (slot < BUFFER_SIZE)
                    shadow_buf[slot] = octet;
            end
            MODE_HOST_RD: begin
                if (slot < BUFFER_SIZE)
                    r.read_data = shadow_buf[slot];
            end
            MODE_SET_REPLY: begin
                reply_len = (len_req > BUFFER_SIZE) ? BUFFER_SIZE : len_req;
            end
            default: begin
                // error event and every spare code
                busy_q      = 1'b0;
                link_status = ST_ERROR;
                last_error  = raw;
            end
        endcase
        r.busy       = busy_q;
        r.status     = link_status;
        r.error_code = last_error;
        return r;
    endfunction

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, label,
                         want, got);
        end
    endfunction

    always @(posedge aclk) begin
        event_result_t want;
        if (!aresetn) begin
            fill_pos    = 0;
            reply_len   = 0;
            link_status = ST_OK;
            last_error  = '0;
            busy_q      = 1'b0;
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                awaited_results.push_back(resolve_event(s_tuser, s_tdata[7:0],
                                                        s_tdata[12:8], s_tdata[18:13],
                                                        s_tdata[26:19]));
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing awaited, data %0h",
                                 $realtime, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
                    check_field("ack_next", want.ack_next, m_tdata[8]);
                    check_field("busy", want.busy, m_tdata[9]);
                    check_field("status", want.status, m_tdata[11:10]);
                    check_field("error_code", want.error_code, m_tdata[19:12]);
                    check_field("message_length", want.message_length, m_tdata[25:20]);
                    check_field("read_data", want.read_data, m_tdata[33:26]);
                    check_field("message_ready", want.message_ready, m_tlast);
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

FILE: tb/i2c_target_message_buffer_core_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the I2C target message buffer. Checking lives in
// message_layer_checker, which sits beside the block on both channels.
module i2c_target_message_buffer_core_test;
    import imb_pkg::*;

    localparam int BUF_ENTRIES   = 32;
    localparam int ITEM_TARGET   = 700;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BACKLOG_HOLD  = 80;     // cycles the receiver sits on m_tready
    localparam int DRAIN_CYCLES  = 8;
    // codes above the last defined mode behave as an error event
    localparam logic [3:0] MODE_SPARE_FIRST = 4'd10;
    localparam logic [3:0] MODE_SPARE_LAST  = 4'd15;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int cycle_count;
    int offered;

    // Stimulus-side bookkeeping, only so that no transaction ever reads a
    // buffer entry that has not been written yet (those read as undefined).
    bit          written [BUF_ENTRIES];
    int unsigned cursor;
    int unsigned reply_len;

    i2c_target_message_buffer_core #(
        .BUFFER_SIZE(BUF_ENTRIES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    message_layer_checker #(
        .BUFFER_SIZE(BUF_ENTRIES)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[i2c_target_message_buffer_core] ERROR");
            $finish;
        end
    end

    // One window in every five is calm: the sender leaves no gaps and the receiver starts no new random stalls.
    function automatic bit calm_window();
        return ((cycle_count / 256) % 5) == 0;
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm_window())
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One s_ transaction: drive at the falling edge, hold until accepted.
    // tvalid stays high across back-to-back transactions.
    task automatic offer(input logic [3:0] kind, input logic [7:0] octet,
                         input logic [4:0] slot, input logic [5:0] len_req,
                         input logic [7:0] raw);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, raw, len_req, slot, octet};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        offered++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Sends one event; if it would read an unwritten entry, that entry is
    // filled by a host write first. Keeps cursor and reply length in step.
    task automatic send_event(input logic [3:0] kind, input logic [7:0] octet,
                              input logic [4:0] slot, input logic [5:0] len_req,
                              input logic [7:0] raw);
        int touched;
        touched = -1;
        case (kind)
            MODE_HOST_RD:   touched = slot;
            MODE_READ_ADDR: if (reply_len > 0) touched = 0;
            MODE_TX_ACK:    if (cursor < reply_len && cursor < BUF_ENTRIES) touched = cursor;
            default: ;
        endcase
        if (touched >= 0 && !written[touched]) begin
            offer(MODE_HOST_WR, 8'($urandom), 5'(touched), 6'($urandom), 8'($urandom));
            written[touched] = 1'b1;
        end
        offer(kind, octet, slot, len_req, raw);
        case (kind)
            MODE_READ_ADDR:  cursor = (reply_len > 0) ? 1 : 0;
            MODE_TX_ACK:     if (cursor < reply_len && cursor < BUF_ENTRIES) cursor++;
            MODE_WRITE_ADDR: cursor = 0;
            MODE_RX_DATA: begin
                if (cursor < BUF_ENTRIES) begin
                    written[cursor] = 1'b1;
                    cursor++;
                end
            end
            MODE_HOST_WR:    written[slot] = 1'b1;
            MODE_SET_REPLY:  reply_len = (len_req > BUF_ENTRIES) ? BUF_ENTRIES : len_req;
            default: ;
        endcase
    endtask

    // Event of the given kind with every field random.
    task automatic fire(input logic [3:0] kind);
        send_event(kind, 8'($urandom), 5'($urandom), 6'($urandom), 8'($urandom));
    endtask

    // Mostly lengths in range, sometimes beyond the buffer (saturates).
    task automatic set_reply_random();
        logic [5:0] len_req;
        len_req = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, BUF_ENTRIES))
                                             : 6'($urandom_range(0, 63));
        send_event(MODE_SET_REPLY, 8'($urandom), 5'($urandom), len_req, 8'($urandom));
    endtask

    task automatic fire_error();
        if ($urandom_range(0, 1))
            fire(MODE_ERROR);
        else
            fire(4'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)));
    endtask

    // Write transfer: address, a run of bytes, then normally a stop. Some runs
    // are long enough to reach the NACK point and overflow the buffer.
    task automatic write_transfer();
        int n;
        int r;
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(28, 34);
        fire(MODE_WRITE_ADDR);
        repeat (n) fire(MODE_RX_DATA);
        r = $urandom_range(0, 9);
        if (r < 8)
            fire(MODE_STOP);
        else if (r < 9)
            fire_error();
    endtask

    // Read transfer: optional new reply length, address, acked bytes (some past the
    // reply end for filler), then mostly a master NACK and mostly a stop.
    task automatic read_transfer();
        int k;
        int r;
        if ($urandom_range(0, 2) != 0)
            set_reply_random();
        fire(MODE_READ_ADDR);
        k = $urandom_range(0, reply_len + 2);
        repeat (k) fire(MODE_TX_ACK);
        r = $urandom_range(0, 9);
        if (r < 7)
            fire(MODE_TX_NACK);
        else if (r < 8)
            fire_error();
        if ($urandom_range(0, 9) < 7)
            fire(MODE_STOP);
    endtask

    task automatic host_access();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
                fire(MODE_HOST_WR);
            else
                fire(MODE_HOST_RD);
        end
    endtask

    // Short directed pass: field extremes, every mode, saturation, partial
    // read, stop after an error and the spare codes.
    task automatic directed_pass();
        send_event(MODE_HOST_WR,    8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_HOST_WR,    8'hFF, 5'd31, 6'd63, 8'hFF);
        send_event(MODE_HOST_RD,    8'h00, 5'd31, 6'd0,  8'h00);
        send_event(MODE_HOST_RD,    8'hFF, 5'd0,  6'd63, 8'hFF);
        send_event(MODE_SET_REPLY,  8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_READ_ADDR,  8'h00, 5'd0,  6'd0,  8'h00);   // filler only
        send_event(MODE_TX_NACK,    8'h00, 5'd0,  6'd0,  8'h00);   // whole reply sent
        send_event(MODE_SET_REPLY,  8'h00, 5'd0,  6'd63, 8'h00);   // saturates
        send_event(MODE_READ_ADDR,  8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_TX_ACK,     8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_TX_NACK,    8'h00, 5'd0,  6'd0,  8'h00);   // partial
        send_event(MODE_STOP,       8'h00, 5'd0,  6'd0,  8'h00);   // partial kept
        send_event(MODE_WRITE_ADDR, 8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_RX_DATA,    8'hFF, 5'd0,  6'd0,  8'h00);
        send_event(MODE_RX_DATA,    8'h00, 5'd31, 6'd63, 8'hFF);
        send_event(MODE_STOP,       8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_ERROR,      8'h00, 5'd0,  6'd0,  8'hFF);
        send_event(MODE_STOP,       8'h00, 5'd0,  6'd0,  8'h00);   // error kept
        send_event(MODE_SPARE_LAST, 8'hFF, 5'd31, 6'd63, 8'h00);
        send_event(MODE_SPARE_FIRST, 8'h00, 5'd0, 6'd0,  8'hA5);
        send_event(MODE_SET_REPLY,  8'h00, 5'd0,  6'd32, 8'h00);
        send_event(MODE_READ_ADDR,  8'h00, 5'd0,  6'd0,  8'h00);
        send_event(MODE_TX_NACK,    8'h00, 5'd0,  6'd0,  8'h00);
    endtask

    // Receiver: random stalls, calm windows, and two long hold-offs while the
    // sender keeps going, so the internal queue fills and s_tready drops.
    initial begin : receiver
        int stall;
        int r;
        int holds_done;
        stall      = 0;
        holds_done = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if ((holds_done == 0 && offered >= 150) || (holds_done == 1 && offered >= 450)) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (BACKLOG_HOLD - 1) @(negedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (calm_window()) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_pass();

        // Mostly well-formed transfers with random content, plus noise.
        while (offered < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                write_transfer();
            else if (r < 70)
                read_transfer();
            else if (r < 82)
                host_access();
            else if (r < 92)
                fire(4'($urandom_range(0, 15)));
            else
                fire_error();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain, then idle for DRAIN_CYCLES so that anything stray can show up.
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("[i2c_target_message_buffer_core] OK");
        else
            $display("[i2c_target_message_buffer_core] ERROR");
        $finish;
    end

endmodule
